// File: rtl/core/ps2mpt_pkg.sv
// ps2mpt_pkg: shared types and constants for the ps/2 mouse packet tracker
// used by ps2mpt_clamp and ps2_mouse_packet_tracker; no dependencies
`default_nettype none

package ps2mpt_pkg;

   // cursor position width and the working width of the update arithmetic
   localparam int POSITION_BITS = 12;
   localparam int LIMIT_BITS    = 12;
   localparam int CALC_BITS     = ((POSITION_BITS > LIMIT_BITS) ? POSITION_BITS : LIMIT_BITS) + 2;
   localparam int DELTA_BITS    = 9;

   // port field widths
   localparam int BYTE_BITS     = 8;
   localparam int COORD_BITS    = 12;
   localparam int BUTTON_BITS   = 3;
   localparam int RSP_BITS      = 2 * COORD_BITS + BUTTON_BITS;
   localparam int RSP_DATA_BITS = ((RSP_BITS + 7) / 8) * 8;
   localparam int RSP_PAD_BITS  = RSP_DATA_BITS - RSP_BITS;
   localparam int CSR_IDX_BITS  = 2;

   // header byte layout
   localparam int SYNC_BIT = 3;

   // clamp bound from the position width
   localparam int POS_MAX_INT = (1 << POSITION_BITS) - 1;
   localparam logic [CALC_BITS-1:0] POS_MAX = CALC_BITS'(POS_MAX_INT);

   // reset values, cursor start clamped to the position range
   localparam int RESET_X_INT = 512;
   localparam int RESET_Y_INT = 384;
   localparam logic [POSITION_BITS-1:0] RESET_X =
      POSITION_BITS'((RESET_X_INT > POS_MAX_INT) ? POS_MAX_INT : RESET_X_INT);
   localparam logic [POSITION_BITS-1:0] RESET_Y =
      POSITION_BITS'((RESET_Y_INT > POS_MAX_INT) ? POS_MAX_INT : RESET_Y_INT);
   localparam logic [LIMIT_BITS-1:0] RESET_X_LIMIT = LIMIT_BITS'(1023);
   localparam logic [LIMIT_BITS-1:0] RESET_Y_LIMIT = LIMIT_BITS'(767);

   // packet byte position
   typedef enum logic [1:0] {
      PHASE_HEADER = 2'd0,
      PHASE_DX     = 2'd1,
      PHASE_DY     = 2'd2
   } phase_type;

   // configuration register indexes
   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_X_LIMIT = 2'd0,
      CSR_Y_LIMIT = 2'd1
   } csr_index_type;

endpackage

`default_nettype wire

// File: rtl/core/ps2mpt_clamp.sv
// ps2mpt_clamp: one axis of the cursor update, add a signed step and clamp
// depends on ps2mpt_pkg
`default_nettype none

module ps2mpt_clamp (
   input  wire logic [ps2mpt_pkg::POSITION_BITS-1:0]     pos_i,
   input  wire logic signed [ps2mpt_pkg::DELTA_BITS-1:0] delta_i,
   input  wire logic [ps2mpt_pkg::LIMIT_BITS-1:0]        limit_i,
   output logic [ps2mpt_pkg::POSITION_BITS-1:0]          pos_o
);
   import ps2mpt_pkg::*;

   logic signed [CALC_BITS-1:0] sum;
   logic [CALC_BITS-1:0]        lim_u;
   logic [CALC_BITS-1:0]        step_u;

   // signed sum, then floor at zero, limit and position range
   always_comb begin
      sum    = signed'(CALC_BITS'(pos_i)) + CALC_BITS'(delta_i);
      lim_u  = CALC_BITS'(limit_i);
      step_u = unsigned'(sum);
      if (sum[CALC_BITS-1]) begin
         step_u = '0;
      end
      if (step_u > lim_u) begin
         step_u = lim_u;
      end
      if (step_u > POS_MAX) begin
         step_u = POS_MAX;
      end
      pos_o = step_u[POSITION_BITS-1:0];
   end

endmodule

`default_nettype wire

// File: rtl/core/ps2_mouse_packet_tracker.sv
// ps2_mouse_packet_tracker: the third byte of a packet is held in the input register, then the
// cursor update writes the result register; throughput one byte per cycle unless a dy byte
// waits on a full result slot, with a combinational cursor update between the input register and result register
// synchronous active-high reset: cursor at 512/384, limits 1023/767,
// waiting for a header byte, no result pending
// depends on ps2mpt_pkg and ps2mpt_clamp
`default_nettype none

module ps2_mouse_packet_tracker (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   // byte stream in
   input  wire logic                                  req_tvalid,
   output logic                                       req_tready,
   input  wire logic [ps2mpt_pkg::BYTE_BITS-1:0]      req_tdata,  // [7:0] data_byte
   // cursor results out
   output logic                                       rsp_tvalid,
   input  wire logic                                  rsp_tready,
   output logic [ps2mpt_pkg::RSP_DATA_BITS-1:0]       rsp_tdata,
   // rsp_tdata: [11:0] cursor_x_out, [23:12] cursor_y_out, [26:24] button_bits,
   // [31:27] zero
   // configuration writes
   input  wire logic                                  csr_valid,
   output logic                                       csr_ready,
   input  wire logic [ps2mpt_pkg::CSR_IDX_BITS-1:0]   csr_index,
   input  wire logic [ps2mpt_pkg::LIMIT_BITS-1:0]     csr_wdata
);
   import ps2mpt_pkg::*;

   // limit registers
   logic [LIMIT_BITS-1:0]    x_limit_ff, x_limit_in;
   logic [LIMIT_BITS-1:0]    y_limit_ff, y_limit_in;

   // input register
   logic                     in_valid_ff, in_valid_in;
   logic [BYTE_BITS-1:0]     in_byte_ff, in_byte_in;

   // packet state
   phase_type                phase_ff, phase_in;
   logic [BUTTON_BITS-1:0]   held_buttons_ff, held_buttons_in;
   logic [BYTE_BITS-1:0]     held_dx_ff, held_dx_in;
   logic [POSITION_BITS-1:0] cursor_x_ff, cursor_x_in;
   logic [POSITION_BITS-1:0] cursor_y_ff, cursor_y_in;

   // result register
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [COORD_BITS-1:0]    rsp_x_ff, rsp_x_in;
   logic [COORD_BITS-1:0]    rsp_y_ff, rsp_y_in;
   logic [BUTTON_BITS-1:0]   rsp_btn_ff, rsp_btn_in;

   logic                     advance;
   logic                     emit;
   logic signed [DELTA_BITS-1:0] dx_step;
   logic signed [DELTA_BITS-1:0] dy_step;
   logic [POSITION_BITS-1:0] new_x;
   logic [POSITION_BITS-1:0] new_y;
   logic [CALC_BITS-1:0]     new_x_ext;
   logic [CALC_BITS-1:0]     new_y_ext;

   // steps: dx adds, dy subtracts
   assign dx_step = signed'({held_dx_ff[BYTE_BITS-1], held_dx_ff});
   assign dy_step = DELTA_BITS'(0) - signed'({in_byte_ff[BYTE_BITS-1], in_byte_ff});

   ps2mpt_clamp u_clamp_x (
      .pos_i   (cursor_x_ff),
      .delta_i (dx_step),
      .limit_i (x_limit_ff),
      .pos_o   (new_x)
   );

   ps2mpt_clamp u_clamp_y (
      .pos_i   (cursor_y_ff),
      .delta_i (dy_step),
      .limit_i (y_limit_ff),
      .pos_o   (new_y)
   );

   assign new_x_ext = CALC_BITS'(new_x);
   assign new_y_ext = CALC_BITS'(new_y);

   // handshakes: a held byte moves on unless it must emit into a full result slot
   assign advance    = in_valid_ff && ((phase_ff != PHASE_DY) || !rsp_valid_ff || rsp_tready);
   assign emit       = advance && (phase_ff == PHASE_DY);
   assign req_tready = !in_valid_ff || advance;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {RSP_PAD_BITS'(0), rsp_btn_ff, rsp_y_ff, rsp_x_ff};

   // configuration write decode
   always_comb begin
      x_limit_in = x_limit_ff;
      y_limit_in = y_limit_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_X_LIMIT: x_limit_in = csr_wdata;
            CSR_Y_LIMIT: y_limit_in = csr_wdata;
            default:     ;
         endcase
      end
   end

   // input register load
   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_tdata;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   // packet state machine and cursor update
   always_comb begin
      phase_in        = phase_ff;
      held_buttons_in = held_buttons_ff;
      held_dx_in      = held_dx_ff;
      cursor_x_in     = cursor_x_ff;
      cursor_y_in     = cursor_y_ff;
      if (advance) begin
         case (phase_ff)
            PHASE_DX: begin
               held_dx_in = in_byte_ff;
               phase_in   = PHASE_DY;
            end
            PHASE_DY: begin
               cursor_x_in = new_x;
               cursor_y_in = new_y;
               phase_in    = PHASE_HEADER;
            end
            default: begin
               // header byte, drop it when the sync bit is clear
               if (in_byte_ff[SYNC_BIT]) begin
                  held_buttons_in = in_byte_ff[BUTTON_BITS-1:0];
                  phase_in        = PHASE_DX;
               end else begin
                  phase_in = PHASE_HEADER;
               end
            end
         endcase
      end
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;
      rsp_btn_in   = rsp_btn_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_x_in     = new_x_ext[COORD_BITS-1:0];
         rsp_y_in     = new_y_ext[COORD_BITS-1:0];
         rsp_btn_in   = held_buttons_ff;
      end
   end

   // control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         x_limit_ff      <= RESET_X_LIMIT;
         y_limit_ff      <= RESET_Y_LIMIT;
         in_valid_ff     <= 1'b0;
         phase_ff        <= PHASE_HEADER;
         held_buttons_ff <= '0;
         held_dx_ff      <= '0;
         cursor_x_ff     <= RESET_X;
         cursor_y_ff     <= RESET_Y;
         rsp_valid_ff    <= 1'b0;
      end else begin
         x_limit_ff      <= x_limit_in;
         y_limit_ff      <= y_limit_in;
         in_valid_ff     <= in_valid_in;
         phase_ff        <= phase_in;
         held_buttons_ff <= held_buttons_in;
         held_dx_ff      <= held_dx_in;
         cursor_x_ff     <= cursor_x_in;
         cursor_y_ff     <= cursor_y_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
      rsp_x_ff   <= rsp_x_in;
      rsp_y_ff   <= rsp_y_in;
      rsp_btn_ff <= rsp_btn_in;
   end

   // a new result only follows the third byte of a packet
   a_rsp_from_dy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(phase_ff == PHASE_DY))
      else $error("result raised without a dy byte");

   // completing a packet returns to header
   a_emit_resyncs: assert property (@(posedge clock) disable iff (reset)
      emit |=> (phase_ff == PHASE_HEADER))
      else $error("phase did not return to header after a packet");

   // cursor moves stay within the limit in force
   a_x_within_limit: assert property (@(posedge clock) disable iff (reset)
      !$stable(cursor_x_ff) && !$past(reset) |->
         (CALC_BITS'(cursor_x_ff) <= CALC_BITS'($past(x_limit_ff))))
      else $error("cursor x above limit");

   a_y_within_limit: assert property (@(posedge clock) disable iff (reset)
      !$stable(cursor_y_ff) && !$past(reset) |->
         (CALC_BITS'(cursor_y_ff) <= CALC_BITS'($past(y_limit_ff))))
      else $error("cursor y above limit");

   // input stalls only behind a held byte that waits on a full result slot
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (in_valid_ff && rsp_valid_ff && (phase_ff == PHASE_DY)))
      else $error("input stalled without cause");

endmodule

`default_nettype wire

// File: tb/ps2_mouse_packet_tracker_test.sv
// ps2_mouse_packet_tracker_test: self-checking bench for the ps/2 mouse packet tracker
// streams header/dx/dy bytes under random back-pressure and checks each cursor report
// depends on ps2mpt_pkg and ps2_mouse_packet_tracker
`timescale 1ns / 100ps

module ps2_mouse_packet_tracker_test;
   import ps2mpt_pkg::*;

   localparam int CLK_PERIOD     = 4;
   localparam int RESET_CYCLES   = 11;
   localparam int SETTLE_CYCLES  = 8;
   localparam int TIMEOUT_CYCLES = 300000;
   localparam int PHASE_BYTES    = 120;
   localparam int MAX_PRINTS     = 40;

   // cursor start, header sync mask and largest byte steps
   localparam int HOME_X = 512;
   localparam int HOME_Y = 384;
   localparam logic [BYTE_BITS-1:0] SYNC_MASK    = BYTE_BITS'(1 << SYNC_BIT);
   localparam logic [BYTE_BITS-1:0] MOVE_POS_MAX = 8'h7F;
   localparam logic [BYTE_BITS-1:0] MOVE_NEG_MAX = 8'h80;

   // register indexes past the end of the map, writes there are dropped
   localparam logic [CSR_IDX_BITS-1:0] CSR_SPARE_LO = 2'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SPARE_HI = 2'd3;

   typedef enum int {DRIFT_NONE, DRIFT_UP, DRIFT_DOWN} drift_type;

   typedef struct packed {
      logic [COORD_BITS-1:0]  x;
      logic [COORD_BITS-1:0]  y;
      logic [BUTTON_BITS-1:0] buttons;
   } cursor_report_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [BYTE_BITS-1:0]     req_tdata = '0;      // [7:0] data_byte
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;           // [11:0] x, [23:12] y, [26:24] buttons
   logic                     csr_valid = 1'b0;
   logic                     csr_ready;
   logic [CSR_IDX_BITS-1:0]  csr_index = '0;
   logic [LIMIT_BITS-1:0]    csr_wdata = '0;

   // stimulus and expectation stores
   logic [BYTE_BITS-1:0] mouse_bytes[$];
   cursor_report_type    cursor_reports[$];
   int                   bytes_loaded = 0;
   int                   bytes_taken = 0;
   int                   mismatch_count = 0;
   int                   send_idle_pct = 0;
   int                   recv_stall_pct = 0;

   // tracker state mirrored by the bench
   phase_type              pkt_phase;
   logic [BUTTON_BITS-1:0] held_btn;
   logic [BYTE_BITS-1:0]   held_dx;
   int                     cur_x;
   int                     cur_y;
   int                     x_limit_cfg;
   int                     y_limit_cfg;

   ps2_mouse_packet_tracker dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #(CLK_PERIOD / 2.0) clock = ~clock;
   end

   // clamp a coordinate to zero, the limit register and the position range
   function automatic int clamp_coord(int v, int limit);
      if (v < 0) v = 0;
      if (v > limit) v = limit;
      if (v > POS_MAX_INT) v = POS_MAX_INT;
      return v;
   endfunction

   // advance the packet tracker by one accepted byte
   function automatic void track_byte(logic [BYTE_BITS-1:0] b);
      cursor_report_type rep;
      bytes_taken++;
      case (pkt_phase)
         PHASE_DX: begin
            held_dx = b;
            pkt_phase = PHASE_DY;
         end
         PHASE_DY: begin
            pkt_phase = PHASE_HEADER;
            cur_x = clamp_coord(cur_x + int'($signed(held_dx)), x_limit_cfg);
            cur_y = clamp_coord(cur_y - int'($signed(b)), y_limit_cfg);
            rep.x = COORD_BITS'(cur_x);
            rep.y = COORD_BITS'(cur_y);
            rep.buttons = held_btn;
            cursor_reports.push_back(rep);
         end
         default: begin
            // out of sync headers are dropped
            if (b[SYNC_BIT]) begin
               held_btn = b[BUTTON_BITS-1:0];
               pkt_phase = PHASE_DX;
            end
         end
      endcase
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      if (mismatch_count < MAX_PRINTS)
         $display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $time);
      mismatch_count++;
   endtask

   task automatic check_report(logic [RSP_DATA_BITS-1:0] data);
      cursor_report_type want;
      if (cursor_reports.size() == 0) begin
         report_mismatch("unexpected report, x", data[COORD_BITS-1:0], 0);
      end else begin
         want = cursor_reports.pop_front();
         if (data[COORD_BITS-1:0] !== want.x)
            report_mismatch("cursor x", data[COORD_BITS-1:0], want.x);
         if (data[2*COORD_BITS-1:COORD_BITS] !== want.y)
            report_mismatch("cursor y", data[2*COORD_BITS-1:COORD_BITS], want.y);
         if (data[RSP_BITS-1:2*COORD_BITS] !== want.buttons)
            report_mismatch("buttons", data[RSP_BITS-1:2*COORD_BITS], want.buttons);
         if (data[RSP_DATA_BITS-1:RSP_BITS] !== '0)
            report_mismatch("pad bits", data[RSP_DATA_BITS-1:RSP_BITS], 0);
      end
   endtask

   // byte driver: holds a transaction until taken, random gaps between them
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (req_tvalid) track_byte(req_tdata);
         if (mouse_bytes.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            req_tvalid <= 1'b1;
            req_tdata  <= mouse_bytes.pop_front();
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // report monitor with random back-pressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) check_report(rsp_tdata);
         rsp_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   task automatic write_csr(logic [CSR_IDX_BITS-1:0] idx, logic [LIMIT_BITS-1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_X_LIMIT: x_limit_cfg = value;
         CSR_Y_LIMIT: y_limit_cfg = value;
         default: ;
      endcase
      csr_valid <= 1'b0;
   endtask

   task automatic set_limits(int xl, int yl);
      write_csr(CSR_X_LIMIT, LIMIT_BITS'(xl));
      write_csr(CSR_Y_LIMIT, LIMIT_BITS'(yl));
   endtask

   task automatic load_byte(logic [BYTE_BITS-1:0] b);
      mouse_bytes.push_back(b);
      bytes_loaded++;
   endtask

   // wait for every byte to be taken and every report to come back
   task automatic wait_drained();
      while (bytes_taken != bytes_loaded || cursor_reports.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic [BYTE_BITS-1:0] pick_delta(drift_type drift, bit y_axis);
      logic [BYTE_BITS-1:0] toward_max;
      // y moves opposite to dy
      toward_max = y_axis ? MOVE_NEG_MAX : MOVE_POS_MAX;
      if (drift != DRIFT_NONE && $urandom_range(0, 99) < 85)
         return (drift == DRIFT_UP) ? toward_max : ~toward_max;
      case ($urandom_range(0, 2))
         0: return BYTE_BITS'($urandom_range(0, 16) - 8);
         1: return BYTE_BITS'($urandom_range(0, 255));
         default: return $urandom_range(0, 1) ? MOVE_POS_MAX : MOVE_NEG_MAX;
      endcase
   endfunction

   // mostly whole packets, some stray bytes that may break framing
   task automatic load_traffic(int count, drift_type drift);
      int added;
      added = 0;
      while (added < count) begin
         if ($urandom_range(0, 99) < 15) begin
            load_byte(BYTE_BITS'($urandom_range(0, 255)));
            added++;
         end else begin
            load_byte(BYTE_BITS'($urandom_range(0, 255)) | SYNC_MASK);
            load_byte(pick_delta(drift, 1'b0));
            load_byte(pick_delta(drift, 1'b1));
            added += 3;
         end
      end
   endtask

   initial begin
      pkt_phase   = PHASE_HEADER;
      held_btn    = '0;
      held_dx     = '0;
      cur_x       = clamp_coord(HOME_X, POS_MAX_INT);
      cur_y       = clamp_coord(HOME_Y, POS_MAX_INT);
      x_limit_cfg = 1023;
      y_limit_cfg = 767;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // directed packets at the reset limits
      send_idle_pct  <= 33;
      recv_stall_pct <= 78;
      load_byte(8'h00);           // no sync bit, dropped
      load_byte(8'hF7);           // everything but sync bit, dropped
      load_byte(8'h08); load_byte(8'h00); load_byte(8'h00);
      load_byte(8'hFF); load_byte(MOVE_POS_MAX); load_byte(MOVE_NEG_MAX);
      load_byte(8'h09); load_byte(MOVE_NEG_MAX); load_byte(MOVE_POS_MAX);
      load_byte(8'h0A); load_byte(8'h01); load_byte(8'hFF);
      load_byte(8'h0C); load_byte(8'hFF); load_byte(8'h01);
      // bytes inside a packet are still data, with or without the sync bit
      load_byte(8'h08); load_byte(8'h00); load_byte(8'h08);
      load_byte(8'h37);
      load_byte(8'h1B); load_byte(MOVE_POS_MAX); load_byte(MOVE_POS_MAX);
      wait_drained();
      load_traffic(PHASE_BYTES - 20, DRIFT_NONE);
      wait_drained();

      // widest limits, push the cursor to the top corner
      set_limits(4095, 4095);
      write_csr(CSR_SPARE_LO, LIMIT_BITS'($urandom_range(0, 4095)));
      load_traffic(PHASE_BYTES, DRIFT_UP);
      wait_drained();

      // collapse the limits under a far cursor, next packet pulls it in
      send_idle_pct  <= 78;
      recv_stall_pct <= 33;
      set_limits(0, 0);
      load_traffic(PHASE_BYTES, DRIFT_NONE);
      wait_drained();

      set_limits(40, 30);
      load_traffic(PHASE_BYTES / 2, DRIFT_UP);
      load_traffic(PHASE_BYTES / 2, DRIFT_NONE);
      wait_drained();

      // no idling from here on
      send_idle_pct  <= 0;
      recv_stall_pct <= 0;
      set_limits($urandom_range(0, 4095), $urandom_range(0, 4095));
      write_csr(CSR_SPARE_HI, LIMIT_BITS'($urandom_range(0, 4095)));
      load_traffic(PHASE_BYTES, DRIFT_NONE);
      wait_drained();

      set_limits(1023, 767);
      load_traffic(PHASE_BYTES / 2, DRIFT_DOWN);
      load_traffic(PHASE_BYTES / 2, DRIFT_NONE);
      wait_drained();

      if (mismatch_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   // hard stop if the handshakes hang
   initial begin
      #(CLK_PERIOD * TIMEOUT_CYCLES);
      $display("status: fail");
      $finish;
   end

endmodule
